FILE: design/timed_priority_led_layer_compositor_top_assert.svh
// Assertion macros shared by the compositor modules.
`ifndef TIMED_PRIORITY_LED_LAYER_COMPOSITOR_TOP_ASSERT_SVH
`define TIMED_PRIORITY_LED_LAYER_COMPOSITOR_TOP_ASSERT_SVH

// Checks a property on every rising clock edge outside reset.
`define TPLC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that a condition never holds on a rising clock edge outside reset.
`define TPLC_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

FILE: design/tplc_pkg.sv
// Package with the shared types and constants of the LED layer compositor.
package tplc_pkg;

    // Default sizes of the layer store.
    localparam int DEF_NUM_LEDS   = 128;
    localparam int DEF_NUM_LAYERS = 3;

    // Operation codes of an input item.
    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_RENDER = 1'b1;

    // One colour layer of one LED.
    typedef struct packed {
        logic        on;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [31:0] expiry;
    } layer_entry_t;

    // Controller states.
    typedef enum logic {
        ST_IDLE,
        ST_PROC
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic process;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_render;
        logic out_busy;
    } ctrl_status_t;

endpackage

FILE: design/tplc_ram.sv
// Generic simple dual-port RAM with a registered read port.
module tplc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: design/tplc_ctrl.sv
// Controller state machine of the LED layer compositor.
module tplc_ctrl
    import tplc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    input  ctrl_status_t status,
    output ctrl_cmd_t    cmd,
    output logic         in_stall
);

`include "timed_priority_led_layer_compositor_top_assert.svh"

    state_t state_reg;
    state_t state_next;
    logic   can_finish;

    // An item may only finish when its result, if any, has a free output slot.
    assign can_finish = !(status.is_render && status.out_busy);

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_PROC;
                end
            end
            ST_PROC:
            begin
                if (can_finish)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs.
    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall   = 1'b0;
                cmd.accept = in_valid;
            end
            ST_PROC:
            begin
                cmd.process = can_finish;
            end
            default:
            begin
                cmd      = '0;
                in_stall = 1'b1;
            end
        endcase
    end

    `TPLC_ASSERT(a_accept_to_proc, cmd.accept |=> (state_reg == ST_PROC), "accepted item not processed")
    `TPLC_ASSERT(a_finish_to_idle, cmd.process |=> (state_reg == ST_IDLE), "no return to idle")
    `TPLC_ASSERT_NEVER(a_accept_and_process, cmd.accept && cmd.process, "accept during processing")

endmodule

FILE: design/tplc_datapath.sv
// Datapath of the LED layer compositor: item registers, layer store and output register.
module tplc_datapath
    import tplc_pkg::*;
#(
    parameter int NUM_LEDS   = DEF_NUM_LEDS,
    parameter int NUM_LAYERS = DEF_NUM_LAYERS
) (
    input  logic         clk,
    input  logic         rst_n,
    input  ctrl_cmd_t    cmd,
    output ctrl_status_t status,
    input  logic         op,
    input  logic [7:0]   led_index,
    input  logic [2:0]   layer,
    input  logic [7:0]   red,
    input  logic [7:0]   green,
    input  logic [7:0]   blue,
    input  logic [23:0]  duration,
    input  logic [31:0]  now,
    input  logic         cfg_we,
    input  logic         cfg_wdata,
    output logic         out_valid,
    input  logic         out_stall,
    output logic [7:0]   pixel_index,
    output logic [7:0]   out_red,
    output logic [7:0]   out_green,
    output logic [7:0]   out_blue
);

`include "timed_priority_led_layer_compositor_top_assert.svh"

    localparam int ADDR_W  = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
    localparam int LAYER_W = (NUM_LAYERS > 1) ? $clog2(NUM_LAYERS) : 1;
    localparam int ROW_W   = NUM_LAYERS * $bits(layer_entry_t);

    typedef layer_entry_t [NUM_LAYERS-1:0] row_t;

    // Item registers.
    logic        op_reg,     op_next;
    logic [7:0]  led_reg,    led_next;
    logic [2:0]  layer_reg,  layer_next;
    logic [7:0]  red_reg,    red_next;
    logic [7:0]  green_reg,  green_next;
    logic [7:0]  blue_reg,   blue_next;
    logic [31:0] expiry_reg, expiry_next;
    logic [31:0] now_reg,    now_next;

    // Configuration and store bookkeeping.
    logic                blackout_reg,  blackout_next;
    logic [NUM_LEDS-1:0] row_valid_reg, row_valid_next;

    // Output register.
    logic       out_valid_reg, out_valid_next;
    logic [7:0] pix_reg,       pix_next;
    logic [7:0] ored_reg,      ored_next;
    logic [7:0] ogreen_reg,    ogreen_next;
    logic [7:0] oblue_reg,     oblue_next;

    // Store access.
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] row_addr;
    logic [ROW_W-1:0]  ram_rd_data;
    logic              ram_we;
    row_t              rd_row;
    row_t              new_row;

    // Render search.
    logic               in_range;
    logic               layer_ok;
    logic               hit;
    logic [LAYER_W-1:0] top_idx;
    layer_entry_t       top_entry;

    assign row_addr = led_reg[ADDR_W-1:0];
    assign rd_addr  = cmd.accept ? led_index[ADDR_W-1:0] : row_addr;
    assign in_range = {1'b0, led_reg} < 9'(NUM_LEDS);
    assign layer_ok = {1'b0, layer_reg} < 4'(NUM_LAYERS);

    // Layer store: one row holds every layer of one LED.
    tplc_ram #(
        .WIDTH (ROW_W),
        .DEPTH (NUM_LEDS)
    ) u_store (
        .clk     (clk),
        .we      (ram_we),
        .wr_addr (row_addr),
        .wr_data (new_row),
        .rd_addr (rd_addr),
        .rd_data (ram_rd_data)
    );

    // A row never written since reset reads as all layers off.
    assign rd_row = (in_range && row_valid_reg[row_addr]) ? row_t'(ram_rd_data) : '0;

    // Item capture; the expiry time is formed on the way in.
    always_comb
    begin
        op_next     = op_reg;
        led_next    = led_reg;
        layer_next  = layer_reg;
        red_next    = red_reg;
        green_next  = green_reg;
        blue_next   = blue_reg;
        expiry_next = expiry_reg;
        now_next    = now_reg;
        if (cmd.accept)
        begin
            op_next     = op;
            led_next    = led_index;
            layer_next  = layer;
            red_next    = red;
            green_next  = green;
            blue_next   = blue;
            expiry_next = now + {8'd0, duration};
            now_next    = now;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        led_reg    <= led_next;
        layer_reg  <= layer_next;
        red_reg    <= red_next;
        green_reg  <= green_next;
        blue_reg   <= blue_next;
        expiry_reg <= expiry_next;
        now_reg    <= now_next;
    end

    // Highest layer that is on; later layers override earlier ones.
    always_comb
    begin
        hit       = 1'b0;
        top_idx   = '0;
        top_entry = '0;
        for (int l = 0; l < NUM_LAYERS; l++)
        begin
            if (rd_row[l].on)
            begin
                hit       = 1'b1;
                top_idx   = LAYER_W'(l);
                top_entry = rd_row[l];
            end
        end
    end

    // Row update: a write sets one layer, a render may turn the shown layer off.
    always_comb
    begin
        new_row = rd_row;
        ram_we  = 1'b0;
        if (cmd.process)
        begin
            if (op_reg == OP_WRITE)
            begin
                if (in_range && layer_ok)
                begin
                    ram_we = 1'b1;
                    for (int l = 0; l < NUM_LAYERS; l++)
                    begin
                        if (layer_reg == 3'(l))
                        begin
                            new_row[l].on     = 1'b1;
                            new_row[l].red    = red_reg;
                            new_row[l].green  = green_reg;
                            new_row[l].blue   = blue_reg;
                            new_row[l].expiry = expiry_reg;
                        end
                    end
                end
            end
            else if (in_range && !blackout_reg && hit && (top_entry.expiry <= now_reg))
            begin
                ram_we = 1'b1;
                for (int l = 0; l < NUM_LAYERS; l++)
                begin
                    if (top_idx == LAYER_W'(l))
                    begin
                        new_row[l].on = 1'b0;
                    end
                end
            end
        end
    end

    // Row valid bits and the blackout register.
    always_comb
    begin
        row_valid_next = row_valid_reg;
        if (ram_we)
        begin
            row_valid_next[row_addr] = 1'b1;
        end
        blackout_next = cfg_we ? cfg_wdata : blackout_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
            blackout_reg  <= 1'b0;
        end
        else
        begin
            row_valid_reg <= row_valid_next;
            blackout_reg  <= blackout_next;
        end
    end

    // Output register: loaded by a finished render, emptied by a transfer.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        pix_next       = pix_reg;
        ored_next      = ored_reg;
        ogreen_next    = ogreen_reg;
        oblue_next     = oblue_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.process && (op_reg == OP_RENDER))
        begin
            out_valid_next = 1'b1;
            pix_next       = led_reg;
            if (in_range && !blackout_reg && hit)
            begin
                ored_next   = top_entry.red;
                ogreen_next = top_entry.green;
                oblue_next  = top_entry.blue;
            end
            else
            begin
                ored_next   = 8'd0;
                ogreen_next = 8'd0;
                oblue_next  = 8'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pix_reg    <= pix_next;
        ored_reg   <= ored_next;
        ogreen_reg <= ogreen_next;
        oblue_reg  <= oblue_next;
    end

    assign out_valid   = out_valid_reg;
    assign pixel_index = pix_reg;
    assign out_red     = ored_reg;
    assign out_green   = ogreen_reg;
    assign out_blue    = oblue_reg;

    assign status.is_render = (op_reg == OP_RENDER);
    assign status.out_busy  = out_valid_reg && out_stall;

    `TPLC_ASSERT_NEVER(a_we_only_in_process, ram_we && !cmd.process,
        "store written outside processing")
    `TPLC_ASSERT_NEVER(a_no_overwrite,
        cmd.process && (op_reg == OP_RENDER) && out_valid_reg && out_stall,
        "held result overwritten")
    `TPLC_ASSERT(a_out_hold,
        (out_valid_reg && out_stall) |=> (out_valid_reg && $stable(pix_reg)),
        "stalled result changed")

endmodule

FILE: design/timed_priority_led_layer_compositor_top.sv
// Top level of the timed priority LED layer compositor.
//
// Input channel (in_valid / in_stall) carries one item per transfer: a layer write
// (op = 0) or a pixel render (op = 1). Output channel (out_valid / out_stall)
// carries one pixel colour per render; writes give no result.
// Each item passes through two steps: accepting it reads the LED's row of layers
// from the store RAM (registered read); processing it picks the top layer and
// writes the row back. The block takes no new item until the last one is through;
// the read-modify-write of the store row sets that limit.
// A render result enters the output register when its processing finishes and
// can be taken at the following rising edge.
// The output register lets the next item be taken while a result waits; if the
// receiver stalls and a second render is ready, the block holds that render and
// stalls its input until the output register is free.
// Reset clears the row valid bits at once, so every layer reads as off, and
// clears blackout; no clearing pass is needed. cfg_we writes blackout and must be
// used only while the block is idle; the block itself does not enforce this.
module timed_priority_led_layer_compositor_top
    import tplc_pkg::*;
#(
    parameter int NUM_LEDS   = DEF_NUM_LEDS,
    parameter int NUM_LAYERS = DEF_NUM_LAYERS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        op,
    input  logic [7:0]  led_index,
    input  logic [2:0]  layer,
    input  logic [7:0]  red,
    input  logic [7:0]  green,
    input  logic [7:0]  blue,
    input  logic [23:0] duration,
    input  logic [31:0] now,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  pixel_index,
    output logic [7:0]  out_red,
    output logic [7:0]  out_green,
    output logic [7:0]  out_blue,
    input  logic        cfg_we,
    input  logic        cfg_wdata
);

    ctrl_cmd_t    cmd;
    ctrl_status_t status;

    // Sequencing of each item.
    tplc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .status   (status),
        .cmd      (cmd),
        .in_stall (in_stall)
    );

    // Store, compositing and output register.
    tplc_datapath #(
        .NUM_LEDS   (NUM_LEDS),
        .NUM_LAYERS (NUM_LAYERS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .op          (op),
        .led_index   (led_index),
        .layer       (layer),
        .red         (red),
        .green       (green),
        .blue        (blue),
        .duration    (duration),
        .now         (now),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .pixel_index (pixel_index),
        .out_red     (out_red),
        .out_green   (out_green),
        .out_blue    (out_blue)
    );

endmodule

FILE: verif/tplc_checker.sv
// Checker for the LED layer compositor: it predicts each rendered pixel and compares it.
`timescale 1ns / 100ps

module tplc_checker
    import tplc_pkg::*;
#(
    parameter int NUM_LEDS   = DEF_NUM_LEDS,
    parameter int NUM_LAYERS = DEF_NUM_LAYERS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic        op,
    input  logic [7:0]  led_index,
    input  logic [2:0]  layer,
    input  logic [7:0]  red,
    input  logic [7:0]  green,
    input  logic [7:0]  blue,
    input  logic [23:0] duration,
    input  logic [31:0] now,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [7:0]  pixel_index,
    input  logic [7:0]  out_red,
    input  logic [7:0]  out_green,
    input  logic [7:0]  out_blue,
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    output int          fail_count,
    output int          pending_pixels
);

    // One rendered pixel as it leaves the block.
    typedef struct packed {
        logic [7:0] index;
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } pixel_t;

    layer_entry_t layer_model [NUM_LEDS * NUM_LAYERS];
    logic         blackout_model;
    pixel_t       expected_pixels [$];

    // A layer write lands only when both the LED and the layer are in range.
    function automatic void store_layer(input logic [7:0] led, input logic [2:0] lay,
                                        input logic [7:0] r, input logic [7:0] g,
                                        input logic [7:0] b, input logic [23:0] dur,
                                        input logic [31:0] t_now);
        int slot;
        if (led < NUM_LEDS && lay < NUM_LAYERS)
        begin
            slot = int'(led) * NUM_LAYERS + int'(lay);
            layer_model[slot].on     = 1'b1;
            layer_model[slot].red    = r;
            layer_model[slot].green  = g;
            layer_model[slot].blue   = b;
            layer_model[slot].expiry = t_now + {8'd0, dur};
        end
    endfunction

    // The top active layer gives the colour; once shown it is dropped if it has expired.
    function automatic pixel_t compose_pixel(input logic [7:0] led, input logic [31:0] t_now);
        pixel_t px;
        int     slot;
        logic   found;
        px       = '0;
        px.index = led;
        found    = 1'b0;
        if (led < NUM_LEDS && !blackout_model)
        begin
            for (int p = NUM_LAYERS - 1; p >= 0; p--)
            begin
                slot = int'(led) * NUM_LAYERS + p;
                if (!found && layer_model[slot].on)
                begin
                    found = 1'b1;
                    px.r  = layer_model[slot].red;
                    px.g  = layer_model[slot].green;
                    px.b  = layer_model[slot].blue;
                    if (layer_model[slot].expiry <= t_now)
                        layer_model[slot].on = 1'b0;
                end
            end
        end
        return px;
    endfunction

    // Counts a failure and reports only the first few.
    task automatic note_failure(input string what, input pixel_t want, input pixel_t seen);
        fail_count++;
        if (fail_count <= 10)
            $display("%0t: %s: expected led %0d rgb %h/%h/%h, got led %0d rgb %h/%h/%h",
                     $time, what, want.index, want.r, want.g, want.b,
                     seen.index, seen.r, seen.g, seen.b);
    endtask

    // Transfers are taken at the rising edge; input items are predicted before results are checked.
    always @(posedge clk or negedge rst_n)
    begin
        pixel_t seen;
        pixel_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_LEDS * NUM_LAYERS; i++)
                layer_model[i] = '0;
            blackout_model = 1'b0;
            expected_pixels.delete();
            fail_count = 0;
        end
        else
        begin
            if (cfg_we)
                blackout_model = cfg_wdata;
            if (in_valid && !in_stall)
            begin
                if (op == OP_RENDER)
                    expected_pixels.push_back(compose_pixel(led_index, now));
                else
                    store_layer(led_index, layer, red, green, blue, duration, now);
            end
            if (out_valid && !out_stall)
            begin
                seen = {pixel_index, out_red, out_green, out_blue};
                if (expected_pixels.size() == 0)
                    note_failure("unexpected pixel", '0, seen);
                else
                begin
                    want = expected_pixels.pop_front();
                    if (seen.index !== want.index || seen.r !== want.r ||
                        seen.g !== want.g || seen.b !== want.b)
                        note_failure("pixel mismatch", want, seen);
                end
            end
        end
        pending_pixels = expected_pixels.size();
    end

endmodule

FILE: verif/tb_timed_priority_led_layer_compositor_top.sv
// Testbench top for the LED layer compositor: stimulus, idling, blackout phases and verdict.
`timescale 1ns / 100ps

module tb_timed_priority_led_layer_compositor_top
    import tplc_pkg::*;
();

    localparam int LED_COUNT   = DEF_NUM_LEDS;
    localparam int LAYER_COUNT = DEF_NUM_LAYERS;

    // Ways in which the receiver holds off results.
    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_TOGGLE
    } stall_mode_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_stall;
    logic        op        = OP_WRITE;
    logic [7:0]  led_index = '0;
    logic [2:0]  layer     = '0;
    logic [7:0]  red       = '0;
    logic [7:0]  green     = '0;
    logic [7:0]  blue      = '0;
    logic [23:0] duration  = '0;
    logic [31:0] now       = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [7:0]  pixel_index;
    logic [7:0]  out_red;
    logic [7:0]  out_green;
    logic [7:0]  out_blue;
    logic        cfg_we    = 1'b0;
    logic        cfg_wdata = 1'b0;

    int          fail_count;
    int          pending_pixels;
    logic [31:0] clock_ms;
    stall_mode_t stall_mode = STALL_NONE;
    int          stall_left = 0;

    always #2 clk = ~clk;

    timed_priority_led_layer_compositor_top #(
        .NUM_LEDS   (LED_COUNT),
        .NUM_LAYERS (LAYER_COUNT)
    ) DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .op          (op),
        .led_index   (led_index),
        .layer       (layer),
        .red         (red),
        .green       (green),
        .blue        (blue),
        .duration    (duration),
        .now         (now),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .pixel_index (pixel_index),
        .out_red     (out_red),
        .out_green   (out_green),
        .out_blue    (out_blue),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata)
    );

    tplc_checker #(
        .NUM_LEDS   (LED_COUNT),
        .NUM_LAYERS (LAYER_COUNT)
    ) checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .op             (op),
        .led_index      (led_index),
        .layer          (layer),
        .red            (red),
        .green          (green),
        .blue           (blue),
        .duration       (duration),
        .now            (now),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .pixel_index    (pixel_index),
        .out_red        (out_red),
        .out_green      (out_green),
        .out_blue       (out_blue),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .fail_count     (fail_count),
        .pending_pixels (pending_pixels)
    );

    // The receiver switches between stall modes, each held for a random stretch.
    always @(negedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = stall_mode_t'($urandom_range(0, 3));
            stall_left = $urandom_range(16, 160);
        end
        else
            stall_left--;
        case (stall_mode)
            STALL_NONE:  out_stall = 1'b0;
            STALL_LIGHT: out_stall = ($urandom_range(0, 2) == 0);
            STALL_HEAVY: out_stall = ($urandom_range(0, 3) != 0);
            default:     out_stall = ~out_stall;
        endcase
    end

    // Presents one item and holds it until the transfer happens.
    task automatic send_item(input logic item_op, input logic [7:0] led, input logic [2:0] lay,
                             input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                             input logic [23:0] dur, input logic [31:0] t_now);
        @(negedge clk);
        op        = item_op;
        led_index = led;
        layer     = lay;
        red       = r;
        green     = g;
        blue      = b;
        duration  = dur;
        now       = t_now;
        in_valid  = 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // Stops sending, waits for every pixel still owed, then lets a write finish inside the block.
    task automatic wait_drained();
        @(negedge clk);
        in_valid = 1'b0;
        while (pending_pixels != 0)
            @(negedge clk);
        repeat (6) @(negedge clk);
    endtask

    // Blackout is changed only with the block idle.
    task automatic write_blackout(input logic value);
        wait_drained();
        cfg_we    = 1'b1;
        cfg_wdata = value;
        @(negedge clk);
        cfg_we    = 1'b0;
    endtask

    // Random items aim at a few busy LEDs with a creeping clock so that layers stack and expire.
    task automatic send_random_item();
        logic [7:0]  led;
        logic [2:0]  lay;
        logic [23:0] dur;
        logic        item_op;
        int          pick;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            led = 8'($urandom_range(0, 5));
        else if (pick < 70)
            led = 8'($urandom_range(LED_COUNT - 3, LED_COUNT - 1));
        else if (pick < 88)
            led = 8'($urandom_range(0, LED_COUNT - 1));
        else
            led = 8'($urandom_range(LED_COUNT, 255));
        if ($urandom_range(0, 99) < 85)
            lay = 3'($urandom_range(0, LAYER_COUNT - 1));
        else
            lay = 3'($urandom_range(0, 7));
        pick = $urandom_range(0, 99);
        if (pick < 20)
            dur = '0;
        else if (pick < 60)
            dur = 24'($urandom_range(0, 40));
        else if (pick < 85)
            dur = 24'($urandom_range(0, 400));
        else
            dur = 24'($urandom());
        pick = $urandom_range(0, 99);
        if (pick < 2)
            clock_ms = $urandom();
        else if (pick < 3)
            clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 200);
        else
            clock_ms = clock_ms + $urandom_range(0, 30);
        item_op = ($urandom_range(0, 99) < 45) ? OP_WRITE : OP_RENDER;
        send_item(item_op, led, lay, 8'($urandom()), 8'($urandom()), 8'($urandom()),
                  dur, clock_ms);
    endtask

    // The sender works in bursts with gaps; one item count may carry a full drain first.
    task automatic run_random(input int count, input int drain_at);
        int burst_left;
        burst_left = 0;
        for (int n = 0; n < count; n++)
        begin
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 24);
                if ($urandom_range(0, 2) != 0)
                begin
                    @(negedge clk);
                    in_valid = 1'b0;
                    repeat ($urandom_range(0, 7)) @(negedge clk);
                end
            end
            burst_left--;
            if (n == drain_at)
                wait_drained();
            send_random_item();
        end
    endtask

    // Overall time limit.
    initial
    begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        int drain_cycles;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        write_blackout(1'b0);

        // Empty store, stacked layers with expiry, and the middle layer.
        send_item(OP_RENDER, 8'd0, 3'd0, 8'h00, 8'h00, 8'h00, 24'd0, 32'd1000);
        send_item(OP_WRITE,  8'd0, 3'd0, 8'hFF, 8'h00, 8'h00, 24'd100, 32'd1000);
        send_item(OP_RENDER, 8'd0, 3'd0, 8'h00, 8'h00, 8'h00, 24'd0, 32'd1050);
        send_item(OP_WRITE,  8'd0, 3'd2, 8'h00, 8'hFF, 8'h00, 24'd0, 32'd1100);
        send_item(OP_WRITE,  8'd0, 3'd1, 8'h00, 8'h00, 8'hFF, 24'd50, 32'd1100);
        send_item(OP_RENDER, 8'd0, 3'd0, 8'h00, 8'h00, 8'h00, 24'd0, 32'd1100);
        send_item(OP_RENDER, 8'd0, 3'd0, 8'h00, 8'h00, 8'h00, 24'd0, 32'd1100);
        send_item(OP_RENDER, 8'd0, 3'd0, 8'h00, 8'h00, 8'h00, 24'd0, 32'd1200);
        send_item(OP_RENDER, 8'd0, 3'd0, 8'h00, 8'h00, 8'h00, 24'd0, 32'd1200);
        send_item(OP_RENDER, 8'd0, 3'd0, 8'h00, 8'h00, 8'h00, 24'd0, 32'd1200);

        // Writes out of range are dropped; renders out of range give black.
        send_item(OP_WRITE,  8'd128, 3'd0, 8'h11, 8'h22, 8'h33, 24'd5, 32'd1200);
        send_item(OP_WRITE,  8'd255, 3'd7, 8'h11, 8'h22, 8'h33, 24'd5, 32'd1200);
        send_item(OP_WRITE,  8'd127, 3'd3, 8'h44, 8'h55, 8'h66, 24'd5, 32'd1200);
        send_item(OP_WRITE,  8'd127, 3'd7, 8'h44, 8'h55, 8'h66, 24'd5, 32'd1200);
        send_item(OP_RENDER, 8'd128, 3'd7, 8'hFF, 8'hFF, 8'hFF, 24'hFFFFFF, 32'd1200);
        send_item(OP_RENDER, 8'd255, 3'd0, 8'h00, 8'h00, 8'h00, 24'd0, 32'd1200);

        // Expiry that wraps past the top of the time range.
        send_item(OP_WRITE,  8'd127, 3'd2, 8'hFF, 8'hFF, 8'hFF, 24'hFFFFFF, 32'hFFFF_FFF0);
        send_item(OP_RENDER, 8'd127, 3'd0, 8'h00, 8'h00, 8'h00, 24'd0, 32'hFFFF_FFFF);
        send_item(OP_RENDER, 8'd127, 3'd0, 8'h00, 8'h00, 8'h00, 24'd0, 32'hFFFF_FFFF);
        send_item(OP_WRITE,  8'd1, 3'd1, 8'h12, 8'h34, 8'h56, 24'hFFFFFF, 32'd0);
        send_item(OP_RENDER, 8'd1, 3'd0, 8'h00, 8'h00, 8'h00, 24'd0, 32'd5);

        // Blackout hides colours but still takes writes and leaves expiry alone.
        write_blackout(1'b1);
        send_item(OP_RENDER, 8'd1, 3'd0, 8'h00, 8'h00, 8'h00, 24'd0, 32'd6);
        send_item(OP_WRITE,  8'd2, 3'd0, 8'hAA, 8'h55, 8'h81, 24'd10, 32'd6);
        send_item(OP_RENDER, 8'd2, 3'd0, 8'h00, 8'h00, 8'h00, 24'd0, 32'd100);
        write_blackout(1'b0);
        send_item(OP_RENDER, 8'd2, 3'd0, 8'h00, 8'h00, 8'h00, 24'd0, 32'd100);
        send_item(OP_RENDER, 8'd2, 3'd0, 8'h00, 8'h00, 8'h00, 24'd0, 32'd100);
        send_item(OP_RENDER, 8'd1, 3'd0, 8'h00, 8'h00, 8'h00, 24'd0, 32'd7);

        // Random traffic in three blackout phases.
        clock_ms = 32'd2000;
        run_random(520, 260);
        write_blackout(1'b1);
        run_random(140, -1);
        write_blackout(1'b0);
        run_random(390, -1);

        // Let the last pixels come out, then give the verdict.
        @(negedge clk);
        in_valid = 1'b0;
        drain_cycles = 0;
        while (pending_pixels != 0 && drain_cycles < 20000)
        begin
            @(negedge clk);
            drain_cycles++;
        end
        repeat (10) @(negedge clk);
        if (fail_count == 0 && pending_pixels == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
